/* hw/rtl/y2bgr_pkg.sv */
// Shared types and constants of the semi-planar quad to BGR converter.
package y2bgr_pkg;

	// One 2x2 quad of a semi-planar 4:2:0 frame.
	typedef struct packed {
		logic [7:0] luma_top_left;
		logic [7:0] luma_top_right;
		logic [7:0] luma_bottom_left;
		logic [7:0] luma_bottom_right;
		logic [7:0] chroma_first;
		logic [7:0] chroma_second;
		logic       end_of_frame;
	} quad_t;

	// One converted and normalized pixel.
	typedef struct packed {
		logic [1:0]         pixel_position;
		logic [7:0]         blue;
		logic [7:0]         green;
		logic [7:0]         red;
		logic signed [31:0] norm_blue;
		logic signed [31:0] norm_green;
		logic signed [31:0] norm_red;
		logic               last_of_quad;
		logic               frame_done;
	} pixel_t;

	// Chroma contribution of one color channel.
	typedef logic signed [15:0] term_t;

	// Classified quad as it waits in the queue between front and back.
	typedef struct packed {
		logic [3:0][7:0] luma;
		term_t           red_term;
		term_t           green_term;
		term_t           blue_term;
		logic            end_of_frame;
	} job_t;

	// Configuration register file.
	typedef struct packed {
		logic               chroma_order;
		logic signed [31:0] scale_blue;
		logic signed [31:0] scale_green;
		logic signed [31:0] scale_red;
		logic signed [31:0] bias_blue;
		logic signed [31:0] bias_green;
		logic signed [31:0] bias_red;
	} cfg_t;

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 32;

	localparam logic [CFG_INDEX_W-1:0] REG_CHROMA_ORDER = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_SCALE_BLUE   = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_SCALE_GREEN  = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_SCALE_RED    = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_BIAS_BLUE    = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_BIAS_GREEN   = 3'd5;
	localparam logic [CFG_INDEX_W-1:0] REG_BIAS_RED     = 3'd6;

	localparam logic signed [31:0] SCALE_RESET = 32'sd65536;

	localparam logic [1:0] POS_LAST = 2'd3;

endpackage

/* hw/rtl/yuv420sp_quad_to_normalized_bgr_unit.sv */
// Top level of the semi-planar 4:2:0 quad to normalized BGR converter.
//
// A quad (four luma bytes and the shared chroma pair) is taken in as a
// transaction on any clock edge where start is high and busy is low. Each
// quad yields four pixel transactions in the order top-left, top-right,
// bottom-left, bottom-right, each shown for exactly one cycle with
// pixel_valid high; the receiver cannot stall them, so it must take every
// pixel in the cycle it appears. The pixels of one quad always come back to
// back. The sustained rate is set by the single pixel datapath in the back
// end, which handles one pixel per cycle. A short queue (QUEUE_DEPTH quads)
// sits between the front end and the back end, so up to that many quads can
// be accepted in consecutive cycles before busy rises. The first pixel of a
// quad that finds the pipeline empty passes from its queue slot through the
// stage 1, stage 2 and stage 3 registers to the pixel output register.
// Configuration registers are written over the cfg channel, which is always
// ready; they must only be changed while no quad is in flight. Writes to
// indexes beyond the register list are ignored.
module yuv420sp_quad_to_normalized_bgr_unit import y2bgr_pkg::*; #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  quad_t                  quad,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	output logic                   pixel_valid,
	output pixel_t                 pixel
);

	cfg_t cfg_q;
	logic push;
	logic pop;
	logic empty;
	logic full;
	job_t push_job;
	job_t head;

	// The register file takes a write in any cycle.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.chroma_order <= 1'b0;
			cfg_q.scale_blue   <= SCALE_RESET;
			cfg_q.scale_green  <= SCALE_RESET;
			cfg_q.scale_red    <= SCALE_RESET;
			cfg_q.bias_blue    <= '0;
			cfg_q.bias_green   <= '0;
			cfg_q.bias_red     <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_CHROMA_ORDER: cfg_q.chroma_order <= cfg_data[0];
				REG_SCALE_BLUE:   cfg_q.scale_blue   <= cfg_data;
				REG_SCALE_GREEN:  cfg_q.scale_green  <= cfg_data;
				REG_SCALE_RED:    cfg_q.scale_red    <= cfg_data;
				REG_BIAS_BLUE:    cfg_q.bias_blue    <= cfg_data;
				REG_BIAS_GREEN:   cfg_q.bias_green   <= cfg_data;
				REG_BIAS_RED:     cfg_q.bias_red     <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// The front end orders the chroma pair and forms the per-channel chroma
	// terms, so that the queue holds everything the pixel walk needs.
	y2bgr_front u_front (
		.start        (start),
		.quad         (quad),
		.chroma_order (cfg_q.chroma_order),
		.full         (full),
		.busy         (busy),
		.push         (push),
		.job          (push_job)
	);

	y2bgr_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.head     (head),
		.empty    (empty),
		.full     (full)
	);

	// The back end reads the head quad once for each of its four pixels and
	// releases it on the last one.
	y2bgr_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.head        (head),
		.empty       (empty),
		.pop         (pop),
		.pixel_valid (pixel_valid),
		.pixel       (pixel)
	);

endmodule

/* hw/rtl/y2bgr_front.sv */
// Front end: accepts quads, clamps and orders chroma, and forms the chroma terms.
module y2bgr_front import y2bgr_pkg::*; (
	input  logic  start,
	input  quad_t quad,
	input  logic  chroma_order,
	input  logic  full,
	output logic  busy,
	output logic  push,
	output job_t  job
);

	localparam logic [7:0] CHROMA_MAX  = 8'd240;
	localparam term_t      CHROMA_MID  = 16'sd128;
	localparam term_t      RED_V       = 16'sd102;
	localparam term_t      GREEN_V     = -16'sd52;
	localparam term_t      GREEN_U     = -16'sd25;
	localparam term_t      BLUE_U      = 16'sd129;

	// Clamp to 240, then center on zero.
	function automatic term_t chroma_offset(input logic [7:0] c);
		logic [7:0] clamped;
		clamped = (c > CHROMA_MAX) ? CHROMA_MAX : c;
		return term_t'({8'd0, clamped}) - CHROMA_MID;
	endfunction

	term_t c_first;
	term_t c_second;
	term_t u;
	term_t v;

	always_comb begin
		c_first  = chroma_offset(quad.chroma_first);
		c_second = chroma_offset(quad.chroma_second);
		u        = chroma_order ? c_second : c_first;
		v        = chroma_order ? c_first : c_second;

		job.luma[0]      = quad.luma_top_left;
		job.luma[1]      = quad.luma_top_right;
		job.luma[2]      = quad.luma_bottom_left;
		job.luma[3]      = quad.luma_bottom_right;
		job.red_term     = v * RED_V;
		job.green_term   = v * GREEN_V + u * GREEN_U;
		job.blue_term    = u * BLUE_U;
		job.end_of_frame = quad.end_of_frame;
	end

	assign busy = full;
	assign push = start && !full;

endmodule

/* hw/rtl/y2bgr_queue.sv */
// Small job queue that decouples the front end from the pixel back end.
module y2bgr_queue import y2bgr_pkg::*; #(
	parameter int DEPTH = 2
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	input  logic pop,
	output job_t head,
	output logic empty,
	output logic full
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL  = CNT_W'(DEPTH);

	job_t             slots_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign empty = (count_q == '0);
	assign full  = (count_q == CNT_FULL);
	assign head  = slots_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_SLOT) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_SLOT) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_job;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_FULL)
		else $error("queue count above depth");

	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> count_q == $past(count_q) + 1'b1)
		else $error("queue count did not grow on push");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("pop from empty queue");

endmodule

/* hw/rtl/y2bgr_back.sv */
// Back end: walks the four pixels of each queued quad through the color pipeline.
module y2bgr_back import y2bgr_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  cfg_t   cfg,
	input  job_t   head,
	input  logic   empty,
	output logic   pop,
	output logic   pixel_valid,
	output pixel_t pixel
);

	typedef logic signed [16:0] sum_t;
	typedef logic signed [40:0] wide_t;

	localparam term_t LUMA_GAIN   = 16'sd74;
	localparam term_t LUMA_OFFSET = -16'sd1135;
	localparam wide_t SAT_MAX     = 41'sd2147483647;
	localparam wide_t SAT_MIN     = -41'sd2147483648;

	// Floor shift by 6, then clamp to a byte.
	function automatic logic [7:0] to_byte(input term_t t, input term_t c);
		sum_t        s;
		logic [10:0] q;
		s = sum_t'(t) + sum_t'(c);
		q = s[16:6];
		if (q[10]) begin
			return 8'd0;
		end else if (q[9:8] != 2'd0) begin
			return 8'd255;
		end
		return q[7:0];
	endfunction

	function automatic logic signed [31:0] sat32(input wide_t x);
		if (x > SAT_MAX) begin
			return 32'sh7fffffff;
		end else if (x < SAT_MIN) begin
			return 32'sh80000000;
		end
		return x[31:0];
	endfunction

	logic [1:0] pos_q;
	logic       issue;

	assign issue = !empty;
	assign pop   = issue && (pos_q == POS_LAST);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (issue) begin
			pos_q <= pos_q + 1'b1;
		end
	end

	// Stage 1: luma term of the selected pixel.
	logic       valid_s1;
	term_t      t_s1;
	term_t      red_term_s1;
	term_t      green_term_s1;
	term_t      blue_term_s1;
	logic [1:0] pos_s1;
	logic       eof_s1;

	// Stage 2: saturated bytes.
	logic       valid_s2;
	logic [7:0] blue_s2;
	logic [7:0] green_s2;
	logic [7:0] red_s2;
	logic [1:0] pos_s2;
	logic       eof_s2;

	// Stage 3: scaled bytes.
	logic       valid_s3;
	logic [7:0] blue_s3;
	logic [7:0] green_s3;
	logic [7:0] red_s3;
	wide_t      prod_blue_s3;
	wide_t      prod_green_s3;
	wide_t      prod_red_s3;
	logic [1:0] pos_s3;
	logic       eof_s3;

	logic   pixel_valid_q;
	pixel_t pixel_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1      <= 1'b0;
			valid_s2      <= 1'b0;
			valid_s3      <= 1'b0;
			pixel_valid_q <= 1'b0;
		end else begin
			valid_s1      <= issue;
			valid_s2      <= valid_s1;
			valid_s3      <= valid_s2;
			pixel_valid_q <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		t_s1          <= term_t'({8'd0, head.luma[pos_q]}) * LUMA_GAIN + LUMA_OFFSET;
		red_term_s1   <= head.red_term;
		green_term_s1 <= head.green_term;
		blue_term_s1  <= head.blue_term;
		pos_s1        <= pos_q;
		eof_s1        <= head.end_of_frame;

		blue_s2  <= to_byte(t_s1, blue_term_s1);
		green_s2 <= to_byte(t_s1, green_term_s1);
		red_s2   <= to_byte(t_s1, red_term_s1);
		pos_s2   <= pos_s1;
		eof_s2   <= eof_s1;

		blue_s3       <= blue_s2;
		green_s3      <= green_s2;
		red_s3        <= red_s2;
		prod_blue_s3  <= wide_t'(cfg.scale_blue) * wide_t'({1'b0, blue_s2});
		prod_green_s3 <= wide_t'(cfg.scale_green) * wide_t'({1'b0, green_s2});
		prod_red_s3   <= wide_t'(cfg.scale_red) * wide_t'({1'b0, red_s2});
		pos_s3        <= pos_s2;
		eof_s3        <= eof_s2;

		pixel_q.pixel_position <= pos_s3;
		pixel_q.blue           <= blue_s3;
		pixel_q.green          <= green_s3;
		pixel_q.red            <= red_s3;
		pixel_q.norm_blue      <= sat32(prod_blue_s3 + wide_t'(cfg.bias_blue));
		pixel_q.norm_green     <= sat32(prod_green_s3 + wide_t'(cfg.bias_green));
		pixel_q.norm_red       <= sat32(prod_red_s3 + wide_t'(cfg.bias_red));
		pixel_q.last_of_quad   <= (pos_s3 == POS_LAST);
		pixel_q.frame_done     <= (pos_s3 == POS_LAST) && eof_s3;
	end

	assign pixel_valid = pixel_valid_q;
	assign pixel       = pixel_q;

	a_quad_contiguous: assert property (@(posedge clk) disable iff (!arst_n)
		pixel_valid_q && (pixel_q.pixel_position != POS_LAST) |=>
		pixel_valid_q && (pixel_q.pixel_position == $past(pixel_q.pixel_position) + 2'd1))
		else $error("pixels of a quad were not delivered back to back");

	a_last_flag: assert property (@(posedge clk) disable iff (!arst_n)
		pixel_valid_q |-> pixel_q.last_of_quad == (pixel_q.pixel_position == POS_LAST))
		else $error("last_of_quad does not match pixel position");

	a_done_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		pixel_valid_q && pixel_q.frame_done |-> pixel_q.last_of_quad)
		else $error("frame_done outside the last pixel of a quad");

endmodule

/* tb/yuv420sp_quad_to_normalized_bgr_unit_tb.sv */
// Self-checking testbench for the semi-planar quad to normalized BGR converter.
`timescale 1ns / 1ps

module yuv420sp_quad_to_normalized_bgr_unit_tb;
	import y2bgr_pkg::*;

	// Cycles with no transaction of any kind before the run is declared hung.
	localparam int STALL_LIMIT = 2000;
	// Cycles to wait after the last pixel before a register write or the end.
	localparam int SETTLE_CYCLES = 8;
	localparam int PHASE_COUNT = 6;
	localparam int QUADS_PER_PHASE = 50;

	// Index past the end of the register file; a write there must change nothing.
	localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 3'd7;

	localparam logic [31:0] Q16_MAX = 32'h7fff_ffff;
	localparam logic [31:0] Q16_MIN = 32'h8000_0000;

	// Keeps a shadow copy of the registers, works out the four pixels of every
	// accepted quad and compares the pixels that come out against them in order.
	class pixel_scoreboard;
		cfg_t   regs;
		pixel_t expected_pixels[$];
		int     errors;
		int     quads_seen;
		int     pixels_checked;

		function new();
			regs.chroma_order = 1'b0;
			regs.scale_blue   = SCALE_RESET;
			regs.scale_green  = SCALE_RESET;
			regs.scale_red    = SCALE_RESET;
			regs.bias_blue    = '0;
			regs.bias_green   = '0;
			regs.bias_red     = '0;
			errors         = 0;
			quads_seen     = 0;
			pixels_checked = 0;
		endfunction

		function void write_register(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
			case (index)
				REG_CHROMA_ORDER: regs.chroma_order = data[0];
				REG_SCALE_BLUE:   regs.scale_blue   = data;
				REG_SCALE_GREEN:  regs.scale_green  = data;
				REG_SCALE_RED:    regs.scale_red    = data;
				REG_BIAS_BLUE:    regs.bias_blue    = data;
				REG_BIAS_GREEN:   regs.bias_green   = data;
				REG_BIAS_RED:     regs.bias_red     = data;
				default: ;
			endcase
		endfunction

		// Chroma is clamped to 240 and then centered on zero.
		function int chroma_offset(logic [7:0] raw);
			int c;
			c = raw;
			if (c > 240)
				c = 240;
			return c - 128;
		endfunction

		// Floor division by 64 followed by clamping to a byte.
		function logic [7:0] saturate_byte(int sum);
			int q;
			q = sum >>> 6;
			if (q < 0)
				q = 0;
			if (q > 255)
				q = 255;
			return q[7:0];
		endfunction

		// The product of a byte and a Q16.16 gain is exact, so only saturation applies.
		function logic signed [31:0] scale_and_bias(logic signed [31:0] gain, logic [7:0] level,
				logic signed [31:0] offset);
			longint r;
			r = longint'(gain) * longint'(level) + longint'(offset);
			if (r > longint'(32'sh7fff_ffff))
				r = longint'(32'sh7fff_ffff);
			if (r < -longint'(32'sh7fff_ffff) - 1)
				r = -longint'(32'sh7fff_ffff) - 1;
			return r[31:0];
		endfunction

		function void note_quad(quad_t q);
			int         u;
			int         v;
			int         first;
			int         second;
			int         luma_term;
			int         red_term;
			int         green_term;
			int         blue_term;
			logic [7:0] lumas [4];
			pixel_t     px;
			first  = chroma_offset(q.chroma_first);
			second = chroma_offset(q.chroma_second);
			if (regs.chroma_order) begin
				v = first;
				u = second;
			end else begin
				u = first;
				v = second;
			end
			red_term   = 102 * v;
			green_term = -52 * v - 25 * u;
			blue_term  = 129 * u;
			lumas = '{q.luma_top_left, q.luma_top_right, q.luma_bottom_left, q.luma_bottom_right};
			for (int k = 0; k < 4; k++) begin
				luma_term = lumas[k];
				luma_term = luma_term * 74 - 1135;
				px.pixel_position = 2'(k);
				px.blue           = saturate_byte(luma_term + blue_term);
				px.green          = saturate_byte(luma_term + green_term);
				px.red            = saturate_byte(luma_term + red_term);
				px.norm_blue      = scale_and_bias(regs.scale_blue, px.blue, regs.bias_blue);
				px.norm_green     = scale_and_bias(regs.scale_green, px.green, regs.bias_green);
				px.norm_red       = scale_and_bias(regs.scale_red, px.red, regs.bias_red);
				px.last_of_quad   = (px.pixel_position == POS_LAST);
				px.frame_done     = px.last_of_quad && q.end_of_frame;
				expected_pixels.push_back(px);
			end
			quads_seen++;
		endfunction

		function void compare_field(string label, logic [31:0] want, logic [31:0] got);
			if (want !== got) begin
				errors++;
				$display("%0t: %s mismatch, expected %0h, got %0h", $time, label, want, got);
			end
		endfunction

		function void check_pixel(pixel_t got);
			pixel_t want;
			if (expected_pixels.size() == 0) begin
				errors++;
				$display("%0t: pixel with none expected, expected nothing, got %0h",
					$time, got);
				return;
			end
			want = expected_pixels.pop_front();
			pixels_checked++;
			compare_field("pixel_position", want.pixel_position, got.pixel_position);
			compare_field("blue", want.blue, got.blue);
			compare_field("green", want.green, got.green);
			compare_field("red", want.red, got.red);
			compare_field("norm_blue", want.norm_blue, got.norm_blue);
			compare_field("norm_green", want.norm_green, got.norm_green);
			compare_field("norm_red", want.norm_red, got.norm_red);
			compare_field("last_of_quad", want.last_of_quad, got.last_of_quad);
			compare_field("frame_done", want.frame_done, got.frame_done);
		endfunction

		function int pending();
			return expected_pixels.size();
		endfunction
	endclass

	logic                   clk;
	logic                   arst_n;
	logic                   start;
	logic                   busy;
	quad_t                  quad;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;
	logic                   pixel_valid;
	pixel_t                 pixel;

	pixel_scoreboard sb;
	int              stall_cycles;

	yuv420sp_quad_to_normalized_bgr_unit dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.quad        (quad),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.pixel_valid (pixel_valid),
		.pixel       (pixel)
	);

	// 12 ns clock period.
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// The receiver cannot hold pixels off, so every pixel shown with pixel_valid
	// is a transaction at this edge. Outputs are read in the active region, which
	// sees the values from before the edge.
	always @(posedge clk) begin
		if (arst_n && pixel_valid === 1'b1)
			sb.check_pixel(pixel);
	end

	// The watchdog restarts on any transaction: quad, pixel or register write.
	// Only a hung block can keep it counting up to the limit.
	always @(posedge clk) begin
		if ((start && !busy) || pixel_valid || (cfg_valid && cfg_ready)) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
				$display("yuv420sp_quad_to_normalized_bgr_unit_tb NOT OK");
				$finish;
			end
		end
	end

	function automatic quad_t make_quad(logic [7:0] tl, logic [7:0] tr, logic [7:0] bl,
			logic [7:0] br, logic [7:0] c0, logic [7:0] c1, logic eof);
		quad_t q;
		q.luma_top_left     = tl;
		q.luma_top_right    = tr;
		q.luma_bottom_left  = bl;
		q.luma_bottom_right = br;
		q.chroma_first      = c0;
		q.chroma_second     = c1;
		q.end_of_frame      = eof;
		return q;
	endfunction

	// A quarter of the chroma bytes are drawn from near the clamp point at 240.
	function automatic logic [7:0] pick_chroma();
		if ($urandom_range(3) == 0)
			return 8'($urandom_range(230, 255));
		return 8'($urandom_range(255));
	endfunction

	function automatic quad_t random_quad();
		return make_quad(8'($urandom_range(255)), 8'($urandom_range(255)),
			8'($urandom_range(255)), 8'($urandom_range(255)),
			pick_chroma(), pick_chroma(), $urandom_range(7) == 0);
	endfunction

	// Q16.16 values: full-range noise, modest gains of either sign, or an extreme.
	function automatic logic [31:0] random_q16();
		case ($urandom_range(3))
			0: return $urandom();
			1: return $urandom_range(32'h0003_0000);
			2: return -$urandom_range(32'h0003_0000);
			default: return $urandom_range(1) ? Q16_MAX : Q16_MIN;
		endcase
	endfunction

	// Offers one quad after a random number of idle cycles and waits for busy to
	// be low at a rising edge. Returns right after the accepting edge with start
	// still high, so a following quad can go out back to back.
	task automatic send_quad(quad_t q, int idle_pct);
		while ($urandom_range(99) < idle_pct) begin
			@(negedge clk);
			start <= 1'b0;
			@(posedge clk);
		end
		@(negedge clk);
		start <= 1'b1;
		quad  <= q;
		forever begin
			@(posedge clk);
			if (!busy)
				break;
		end
		sb.note_quad(q);
	endtask

	// Leaves cfg_valid high on return; the caller lowers it after its last write.
	task automatic write_reg(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data  <= data;
		forever begin
			@(posedge clk);
			if (cfg_ready)
				break;
		end
		sb.write_register(index, data);
	endtask

	// Waits until every expected pixel has arrived, then lets the pipeline settle.
	task automatic wait_idle();
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Each phase writes the whole register file. Phase 0 uses modest gains and
	// offsets, phases 1 and 2 drive them to their extremes so that the normalization
	// saturates both ways, phase 3 zeroes the gains; the later ones use random values.
	task automatic configure_phase(int phase);
		logic [31:0] gains [3];
		logic [31:0] offsets [3];
		logic        order;
		case (phase)
			0: begin
				order   = 1'b1;
				gains   = '{$urandom_range(32'h0003_0000), $urandom_range(32'h0003_0000),
					$urandom_range(32'h0003_0000)};
				offsets = '{$urandom_range(32'h0020_0000) - 32'h0010_0000,
					$urandom_range(32'h0020_0000) - 32'h0010_0000,
					$urandom_range(32'h0020_0000) - 32'h0010_0000};
			end
			1: begin
				order   = 1'b0;
				gains   = '{Q16_MAX, Q16_MIN, Q16_MAX};
				offsets = '{Q16_MAX, Q16_MIN, Q16_MIN};
			end
			2: begin
				order   = 1'b1;
				gains   = '{Q16_MIN, Q16_MAX, Q16_MIN};
				offsets = '{Q16_MIN, Q16_MAX, Q16_MAX};
			end
			3: begin
				order   = 1'b0;
				gains   = '{32'h0, 32'h0, 32'h0};
				offsets = '{random_q16(), random_q16(), random_q16()};
			end
			default: begin
				order   = 1'($urandom_range(1));
				gains   = '{random_q16(), random_q16(), random_q16()};
				offsets = '{random_q16(), random_q16(), random_q16()};
			end
		endcase
		// The upper bits of the chroma order word carry noise that must be ignored.
		write_reg(REG_CHROMA_ORDER, ($urandom() & ~32'h1) | {31'b0, order});
		write_reg(REG_SCALE_BLUE, gains[0]);
		write_reg(REG_SCALE_GREEN, gains[1]);
		write_reg(REG_SCALE_RED, gains[2]);
		write_reg(REG_BIAS_BLUE, offsets[0]);
		write_reg(REG_BIAS_GREEN, offsets[1]);
		write_reg(REG_BIAS_RED, offsets[2]);
		write_reg(REG_UNUSED, $urandom());
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		quad_t directed [$];
		int    idle_pct;
		sb           = new();
		stall_cycles = 0;
		arst_n       = 1'b0;
		start        = 1'b0;
		quad         = '0;
		cfg_valid    = 1'b0;
		cfg_index    = '0;
		cfg_data     = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed quads under the reset settings (NV12, unit gain, no offset):
		// chroma at zero, at the clamp point, just above it and at full scale,
		// neutral gray, luma at both ends, alternating bit patterns, and the
		// end-of-frame flag.
		directed.push_back(make_quad(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0));
		directed.push_back(make_quad(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 1'b1));
		directed.push_back(make_quad(8'd16, 8'd235, 8'd81, 8'd145, 8'd128, 8'd128, 1'b0));
		directed.push_back(make_quad(8'd255, 8'd0, 8'd255, 8'd0, 8'd240, 8'd240, 1'b0));
		directed.push_back(make_quad(8'd0, 8'd255, 8'd0, 8'd255, 8'd241, 8'd16, 1'b1));
		directed.push_back(make_quad(8'd128, 8'd128, 8'd128, 8'd128, 8'd0, 8'd255, 1'b0));
		directed.push_back(make_quad(8'd128, 8'd128, 8'd128, 8'd128, 8'd255, 8'd0, 1'b0));
		directed.push_back(make_quad(8'd16, 8'd16, 8'd16, 8'd16, 8'd16, 8'd16, 1'b0));
		directed.push_back(make_quad(8'd235, 8'd235, 8'd235, 8'd235, 8'd240, 8'd240, 1'b1));
		directed.push_back(make_quad(8'd1, 8'd2, 8'd3, 8'd4, 8'd127, 8'd129, 1'b0));
		directed.push_back(make_quad(8'd200, 8'd100, 8'd50, 8'd25, 8'd90, 8'd240, 1'b0));
		directed.push_back(make_quad(8'd254, 8'd253, 8'd252, 8'd251, 8'd239, 8'd241, 1'b0));
		directed.push_back(make_quad(8'haa, 8'h55, 8'haa, 8'h55, 8'haa, 8'h55, 1'b1));
		directed.push_back(make_quad(8'h55, 8'haa, 8'h55, 8'haa, 8'h55, 8'haa, 1'b0));

		// Back to back, so the queue in front of the pixel datapath fills up and
		// busy has to hold the sender off.
		foreach (directed[i])
			send_quad(directed[i], 0);
		@(negedge clk);
		start <= 1'b0;
		wait_idle();

		// Random phases. The sender idles 30 percent of the time in the first
		// two, 71 percent in the next two and never in the last two.
		for (int phase = 0; phase < PHASE_COUNT; phase++) begin
			configure_phase(phase);
			idle_pct = (phase < 2) ? 30 : (phase < 4) ? 71 : 0;
			repeat (QUADS_PER_PHASE)
				send_quad(random_quad(), idle_pct);
			@(negedge clk);
			start <= 1'b0;
			wait_idle();
		end

		$display("Checked %0d pixels from %0d quads over %0d register settings,",
			sb.pixels_checked, sb.quads_seen, PHASE_COUNT + 1);
		$display("covering both chroma orders, chroma clamping and saturated gains and offsets.");
		if (sb.errors == 0) begin
			$display("yuv420sp_quad_to_normalized_bgr_unit_tb OK");
		end else begin
			$display("yuv420sp_quad_to_normalized_bgr_unit_tb NOT OK");
		end
		$finish;
	end

endmodule
